@@ rtl/tgad_pkg.sv @@
// Package for the torus gadget decomposition block.
// Holds the payload structs, register indexes and fixed widths; no dependencies.
`default_nettype none

package tgad_pkg;

  localparam int DIGIT_WIDTH   = 32;
  localparam int MAX_PRECISION = 50;
  localparam int RESULT_LIMIT  = 50;
  localparam int CFG_WIDTH     = 6;

  // Register indexes on the configuration port.
  localparam logic REG_DIGIT_BITS  = 1'b0;
  localparam logic REG_DIGIT_COUNT = 1'b1;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        vector_end;
  } tgad_in_t;

  typedef struct packed {
    logic signed [DIGIT_WIDTH-1:0] digit;
    logic                          last_digit;
    logic                          vector_end_out;
    logic                          config_error;
  } tgad_out_t;

  // Per-item control that travels alongside the adder pipeline.
  typedef struct packed {
    logic        vend;
    logic [5:0]  k;
    logic [5:0]  n;
    logic        bad;
    logic [5:0]  sh0;
    logic        spec;
    logic [49:0] specv;
  } tgad_ctl_t;

endpackage

`default_nettype wire

@@ rtl/torus_gadget_approx_decompose_unit.sv @@
// The first digit of an item reaches the result port through the pipeline and the emitter.
// Throughput: one digit per cycle while res_stall is low. Each item gives n digits,
// n = digit_count (1 when digit_count is zero, at most 50); the next loads with its last digit.
// An eight-stage pipeline (constant build, then double-precision add) feeds the emitter;
// stall holds every stage.
// Reset is synchronous: it clears all valid bits and sets both registers to 1.
`default_nettype none

module torus_gadget_approx_decompose_unit
  import tgad_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire tgad_in_t             item,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output tgad_out_t                 res,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  logic [5:0] digit_bits;
  logic [5:0] digit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_bits  <= 6'd1;
      digit_count <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIGIT_BITS:  digit_bits  <= cfg_data;
        REG_DIGIT_COUNT: digit_count <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  // Stage 1: capture the item and the precision product.
  logic [63:0] x1;
  logic        vend1;
  logic [5:0]  k1, ell1;
  logic [11:0] p1;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= item.value_bits;
      vend1 <= item.vector_end;
      k1    <= digit_bits;
      ell1  <= digit_count;
      p1    <= {6'd0, digit_bits} * {6'd0, digit_count};
    end
  end

  // Stage 2: rounding constant as an exact double, mantissa C and exponent 1075 - P.
  logic        bad1;
  logic [49:0] cbits1;
  logic [11:0] pos1;
  logic [11:0] cexp_w1;
  tgad_ctl_t   ctl1;

  always_comb begin
    bad1   = (k1 == 6'd0) || (ell1 == 6'd0) || (p1 > 12'(MAX_PRECISION));
    cbits1 = '0;
    for (int i = 0; i < MAX_PRECISION; i++) begin
      pos1 = p1 - 12'd1 - 12'(i) * {6'd0, k1};
      if (!bad1 && (6'(i) < ell1) && (pos1 < 12'd50)) begin
        cbits1[pos1[5:0]] = 1'b1;
      end
    end
    cexp_w1    = 12'd1075 - p1;
    ctl1.vend  = vend1;
    ctl1.k     = k1;
    ctl1.n     = (ell1 == 6'd0) ? 6'd1 :
                 (ell1 > 6'(RESULT_LIMIT)) ? 6'(RESULT_LIMIT) : ell1;
    ctl1.bad   = bad1;
    ctl1.sh0   = p1[5:0] - k1;
    ctl1.spec  = (x1[62:52] == 11'h7ff);
    ctl1.specv = x1[49:0];
  end

  logic [63:0] x2;
  logic [52:0] c2;
  logic [10:0] ce2;
  tgad_ctl_t   ctl2;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2   <= x1;
      c2   <= {2'b11, 1'b0, cbits1};
      ce2  <= cexp_w1[10:0];
      ctl2 <= ctl1;
    end
  end

  // Stage 3: unpack the input and order the operands by magnitude.
  logic [10:0] xe2;
  logic [52:0] xm2;
  logic        xbig2;

  always_comb begin
    xe2   = (x2[62:52] == 11'd0) ? 11'd1 : x2[62:52];
    xm2   = {(x2[62:52] != 11'd0), x2[51:0]};
    xbig2 = {xe2, xm2} >= {ce2, c2};
  end

  logic [52:0] bigm3, smallm3;
  logic [10:0] bige3, d3;
  logic        sub3;
  tgad_ctl_t   ctl3;

  always_ff @(posedge clk) begin
    if (adv) begin
      bigm3   <= xbig2 ? xm2 : c2;
      smallm3 <= xbig2 ? c2 : xm2;
      bige3   <= xbig2 ? xe2 : ce2;
      d3      <= xbig2 ? (xe2 - ce2) : (ce2 - xe2);
      sub3    <= x2[63];
      ctl3    <= ctl2;
    end
  end

  // Stage 4: align the smaller operand with guard, round and sticky bits.
  logic [55:0] sext3, salign3, lost3;

  always_comb begin
    sext3 = {smallm3, 3'b000};
    if (d3 >= 11'd56) begin
      salign3 = {55'd0, |smallm3};
      lost3   = '0;
    end else begin
      salign3 = sext3 >> d3[5:0];
      lost3   = sext3 & ~({56{1'b1}} << d3[5:0]);
      salign3[0] = salign3[0] | (|lost3);
    end
  end

  logic [55:0] bigx4, smallx4;
  logic [10:0] e4;
  logic        sub4;
  tgad_ctl_t   ctl4;

  always_ff @(posedge clk) begin
    if (adv) begin
      bigx4   <= {bigm3, 3'b000};
      smallx4 <= salign3;
      e4      <= bige3;
      sub4    <= sub3;
      ctl4    <= ctl3;
    end
  end

  // Stage 5: magnitude add or subtract.
  logic [56:0] sum5;
  logic [10:0] e5;
  tgad_ctl_t   ctl5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum5 <= sub4 ? ({1'b0, bigx4} - {1'b0, smallx4}) : ({1'b0, bigx4} + {1'b0, smallx4});
      e5   <= e4;
      ctl5 <= ctl4;
    end
  end

  // Stage 6: leading zero count, limited so the exponent does not drop below one.
  logic [5:0]  lz5;
  logic [10:0] em1_5;
  logic [5:0]  shamt5;

  always_comb begin
    lz5 = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (sum5[i]) lz5 = 6'(55 - i);
    end
    em1_5  = e5 - 11'd1;
    shamt5 = ({5'd0, lz5} < em1_5) ? lz5 : em1_5[5:0];
  end

  logic [56:0] sum6;
  logic [10:0] e6;
  logic [5:0]  shamt6;
  tgad_ctl_t   ctl6;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum6   <= sum5;
      e6     <= e5;
      shamt6 <= shamt5;
      ctl6   <= ctl5;
    end
  end

  // Stage 7: normalize.
  logic [55:0] m7;
  logic [11:0] e7;
  tgad_ctl_t   ctl7;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum6[56]) begin
        m7 <= {sum6[56:2], sum6[1] | sum6[0]};
        e7 <= {1'b0, e6} + 12'd1;
      end else begin
        m7 <= sum6[55:0] << shamt6;
        e7 <= {1'b0, e6} - {6'd0, shamt6};
      end
      ctl7 <= ctl6;
    end
  end

  // Stage 8: round to nearest even; overflow to infinity clears the fraction; NaN bits pass.
  logic [52:0] mant7;
  logic        rup7;
  logic [53:0] mr7;
  logic [11:0] ef7;
  logic [49:0] low7;

  always_comb begin
    mant7 = m7[55:3];
    rup7  = m7[2] & (m7[1] | m7[0] | mant7[0]);
    mr7   = {1'b0, mant7} + {53'd0, rup7};
    ef7   = mr7[53] ? (e7 + 12'd1) : e7;
    low7  = mr7[53] ? mr7[50:1] : mr7[49:0];
    if (ef7 >= 12'd2047) low7 = '0;
    if (ctl7.spec) low7 = ctl7.specv;
  end

  logic [49:0] sum8;
  tgad_ctl_t   ctl8;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum8 <= low7;
      ctl8 <= ctl7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= {item_valid, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  // Digit emitter: cuts one digit per transfer from the held sum, most significant first.
  logic        e_valid;
  logic [49:0] e_sum;
  logic [5:0]  e_k, e_n, e_idx, e_sh;
  logic        e_bad, e_vend;
  logic        e_final, o_load, e_free;

  logic [49:0] field;
  logic [49:0] kmask;
  logic [31:0] half;
  logic [31:0] dval;
  tgad_out_t   res_next;

  always_comb begin
    e_final = (e_idx == (e_n - 6'd1));
    o_load  = e_valid & (~res_valid | ~res_stall);
    e_free  = ~e_valid | (o_load & e_final);
    adv     = ~v8 | e_free;
    item_stall = ~adv;

    field = e_sum >> e_sh;
    kmask = ~({50{1'b1}} << e_k);
    half  = (e_k <= 6'd32) ? (32'd1 << (e_k - 6'd1)) : 32'd0;
    dval  = (field[31:0] & kmask[31:0]) - half;

    res_next.digit          = e_bad ? '0 : dval;
    res_next.last_digit     = e_final;
    res_next.vector_end_out = e_final & e_vend;
    res_next.config_error   = e_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_free) begin
      e_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free) begin
      e_sum  <= sum8;
      e_k    <= ctl8.k;
      e_n    <= ctl8.n;
      e_idx  <= 6'd0;
      e_sh   <= ctl8.sh0;
      e_bad  <= ctl8.bad;
      e_vend <= ctl8.vend;
    end else if (o_load) begin
      e_idx <= e_idx + 6'd1;
      e_sh  <= e_sh - e_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (~res_valid | ~res_stall) begin
      res_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
